// ----- rtl/core/arpc_pkg.sv -----
// arpc_pkg: shared widths, action codes and structs of the address cache
package arpc_pkg;

  localparam int ACT_W  = 2;
  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int LIFE_W = 16;
  localparam int SEC_W  = 32;

  localparam logic [ACT_W-1:0]  ACT_LOOKUP = 2'd0;
  localparam logic [ACT_W-1:0]  ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0]  ACT_TICK   = 2'd2;

  localparam logic [LIFE_W-1:0] LIFE_RESET = 16'd15;

  // query record walking the row of cells
  typedef struct packed {
    logic             ins;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic             hit;
    logic [MAC_W-1:0] hit_mac;
    logic             free_ok;
  } pkt_t;

  // entry written into the chosen cell
  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic [SEC_W-1:0] expiry;
  } wr_t;

endpackage

// ----- rtl/core/arpc_in_if.sv -----
// arpc_in_if: request channel carrying one cache action per transfer
interface arpc_in_if import arpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [IP_W-1:0]  ip_address;
  logic [MAC_W-1:0] mac_address;

  modport source (output valid, action, ip_address, mac_address, input ready);
  modport sink (input valid, action, ip_address, mac_address, output ready);
endinterface

// ----- rtl/core/arpc_out_if.sv -----
// arpc_out_if: result channel carrying one lookup or insert answer per transfer
interface arpc_out_if import arpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [MAC_W-1:0] found_mac;
  logic             table_full;

  modport source (output valid, hit, found_mac, table_full, input ready);
  modport sink (input valid, hit, found_mac, table_full, output ready);
endinterface

// ----- rtl/core/arpc_cell.sv -----
// arpc_cell: one cache slot that ages, matches and hands the query record on
module arpc_cell import arpc_pkg::*; #(
  parameter int IDX_W = 4,
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [SEC_W-1:0] now,
  input  logic             tok_in,
  input  pkt_t             pkt_in,
  input  logic [IDX_W-1:0] fidx_in,
  output logic             tok_out,
  output pkt_t             pkt_out,
  output logic [IDX_W-1:0] fidx_out,
  input  logic             wr_sel,
  input  wr_t              wr_data
);

  logic             valid_r;
  logic             valid_nxt;
  logic [IP_W-1:0]  ip_r;
  logic [MAC_W-1:0] mac_r;
  logic [SEC_W-1:0] exp_r;
  logic             tok_r;
  pkt_t             pkt_r;
  pkt_t             pkt_nxt;
  logic [IDX_W-1:0] fidx_r;
  logic [IDX_W-1:0] fidx_nxt;
  logic             live;

  assign live = valid_r && (exp_r > now);

  always_comb begin
    valid_nxt = valid_r;
    pkt_nxt   = pkt_in;
    fidx_nxt  = fidx_in;
    if (wr_sel) begin
      valid_nxt = 1'b1;
    end else if (tok_in) begin
      valid_nxt = live;
    end
    if (!pkt_in.hit && live && (ip_r == pkt_in.ip)) begin
      pkt_nxt.hit     = 1'b1;
      pkt_nxt.hit_mac = mac_r;
    end
    if (!pkt_in.free_ok && !live) begin
      pkt_nxt.free_ok = 1'b1;
      fidx_nxt        = IDX_W'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    pkt_r  <= pkt_nxt;
    fidx_r <= fidx_nxt;
    if (wr_sel) begin
      ip_r  <= wr_data.ip;
      mac_r <= wr_data.mac;
      exp_r <= wr_data.expiry;
    end
  end

  assign tok_out  = tok_r;
  assign pkt_out  = pkt_r;
  assign fidx_out = fidx_r;

endmodule

// ----- rtl/core/arp_cache_with_aging.sv -----
// arp_cache_with_aging: IPv4 to MAC cache with aging built as a row of slot cells
//
// A lookup or insert walks the row one cell per cycle; the record leaving the
// row is captured, then a finishing step writes the new entry and loads the
// result register once that register is free; a new request is taken the cycle
// after that. A tick or an unused action is taken while idle and gives no
// answer. While an answer waits in the result register the block still takes
// ticks and starts the next walk; a walk that finishes before the answer is
// taken waits at the end of the row. Each cell drops its entry when the walk
// finds it expired, and the walk reports the lowest live match and the lowest
// free slot. All slots are empty straight after reset, with no clearing pass.
module arp_cache_with_aging import arpc_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  arpc_in_if.sink           in_if,
  arpc_out_if.source        out_if,
  input  logic              cfg_wr_en,
  input  logic [LIFE_W-1:0] cfg_wr_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  logic [SEC_W-1:0]  now_r;
  logic [LIFE_W-1:0] life_r;

  logic [ENTRIES:0]  tok_v;
  pkt_t              pkt_a  [0:ENTRIES];
  logic [IDX_W-1:0]  fidx_a [0:ENTRIES];
  logic [ENTRIES-1:0] wr_sel;
  wr_t               wr_data;

  pkt_t              fin_r;
  logic [IDX_W-1:0]  fin_idx_r;

  logic              out_valid_r;
  logic              out_hit_r;
  logic [MAC_W-1:0]  out_mac_r;
  logic              out_full_r;

  logic              in_xfer;
  logic              is_query;
  logic              out_free;
  logic              fin_go;
  logic              ins_do;
  logic              new_live;
  logic [SEC_W-1:0]  expiry;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;
  assign is_query    = (in_if.action == ACT_LOOKUP) || (in_if.action == ACT_INSERT);
  assign out_free    = !out_valid_r || out_if.ready;
  assign fin_go      = (state_r == ST_FIN) && out_free;

  // head of the row
  assign tok_v[0]           = in_xfer && is_query;
  assign pkt_a[0].ins       = (in_if.action == ACT_INSERT);
  assign pkt_a[0].ip        = in_if.ip_address;
  assign pkt_a[0].mac       = in_if.mac_address;
  assign pkt_a[0].hit       = 1'b0;
  assign pkt_a[0].hit_mac   = '0;
  assign pkt_a[0].free_ok   = 1'b0;
  assign fidx_a[0]          = '0;

  assign expiry   = now_r + SEC_W'(life_r);
  assign ins_do   = fin_r.ins && !fin_r.hit && fin_r.free_ok;
  assign new_live = ins_do && (expiry > now_r);

  assign wr_data.ip     = fin_r.ip;
  assign wr_data.mac    = fin_r.mac;
  assign wr_data.expiry = expiry;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    assign wr_sel[k] = fin_go && ins_do && (fin_idx_r == IDX_W'(k));

    arpc_cell #(
      .IDX_W (IDX_W),
      .INDEX (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .now      (now_r),
      .tok_in   (tok_v[k]),
      .pkt_in   (pkt_a[k]),
      .fidx_in  (fidx_a[k]),
      .tok_out  (tok_v[k+1]),
      .pkt_out  (pkt_a[k+1]),
      .fidx_out (fidx_a[k+1]),
      .wr_sel   (wr_sel[k]),
      .wr_data  (wr_data)
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (tok_v[0]) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok_v[ENTRIES]) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      life_r      <= LIFE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer && (in_if.action == ACT_TICK)) begin
        now_r <= now_r + 1'b1;
      end
      if (cfg_wr_en) begin
        life_r <= cfg_wr_data;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_SCAN) && tok_v[ENTRIES]) begin
      fin_r     <= pkt_a[ENTRIES];
      fin_idx_r <= fidx_a[ENTRIES];
    end
    if (fin_go) begin
      out_hit_r  <= fin_r.hit || new_live;
      out_full_r <= fin_r.ins && !fin_r.hit && !fin_r.free_ok;
      if (fin_r.hit) begin
        out_mac_r <= fin_r.hit_mac;
      end else if (new_live) begin
        out_mac_r <= fin_r.mac;
      end else begin
        out_mac_r <= '0;
      end
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.hit        = out_hit_r;
  assign out_if.found_mac  = out_mac_r;
  assign out_if.table_full = out_full_r;

  // at most one query walks the row
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_v[ENTRIES:1]))
    else $error("more than one query in the row");

  // the row is empty whenever a request can be taken
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (tok_v[ENTRIES:1] == '0))
    else $error("query in the row while idle");

  // a fill goes to one slot only
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(wr_sel))
    else $error("more than one slot written");

  // a dropped insert never reports a hit
  a_full_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_full_r))
    else $error("hit and table full together");

  // a tick transfer advances the seconds counter by one
  a_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_if.action == ACT_TICK)) |=>
      (now_r == SEC_W'($past(now_r) + 1'b1)))
    else $error("seconds counter did not advance");

endmodule

// ----- tb/sv/arp_cache_with_aging_test.sv -----
// arp_cache_with_aging_test: self-checking testbench for the aging address cache
typedef struct packed {
  logic        hit;
  logic [47:0] mac;
  logic        full;
} cache_answer_t;

class mac_table;
  localparam int SLOTS = 16;

  bit            slot_used[SLOTS];
  bit [31:0]     slot_ip[SLOTS];
  bit [47:0]     slot_mac[SLOTS];
  bit [31:0]     slot_exp[SLOTS];
  bit [31:0]     now_s;
  bit [15:0]     lifetime = arpc_pkg::LIFE_RESET;
  cache_answer_t answers_due[$];
  int            errors;
  int            n_lookup, n_insert, n_hit, n_full, n_tick;

  function bit live(int k);
    return slot_used[k] && (slot_exp[k] > now_s);
  endfunction

  function int find(bit [31:0] ip);
    for (int k = 0; k < SLOTS; k++) begin
      if (live(k) && slot_ip[k] == ip) return k;
    end
    return -1;
  endfunction

  function void note_request(logic [1:0] act, logic [31:0] ip, logic [47:0] mac);
    cache_answer_t a;
    int k;
    int f;
    if (act == arpc_pkg::ACT_TICK) begin
      now_s++;
      n_tick++;
      return;
    end
    if (act != arpc_pkg::ACT_LOOKUP && act != arpc_pkg::ACT_INSERT) return;
    // aged entries are dropped before the search
    for (k = 0; k < SLOTS; k++) begin
      if (!live(k)) slot_used[k] = 1'b0;
    end
    a = '0;
    k = find(ip);
    if (act == arpc_pkg::ACT_INSERT) n_insert++;
    else n_lookup++;
    if (act == arpc_pkg::ACT_INSERT && k < 0) begin
      f = 0;
      while (f < SLOTS && slot_used[f]) f++;
      if (f == SLOTS) begin
        a.full = 1'b1;
        n_full++;
        answers_due.push_back(a);
        return;
      end
      slot_used[f] = 1'b1;
      slot_ip[f]   = ip;
      slot_mac[f]  = mac;
      slot_exp[f]  = now_s + 32'(lifetime);
      k = find(ip);
    end
    if (k >= 0) begin
      a.hit = 1'b1;
      a.mac = slot_mac[k];
      n_hit++;
    end
    answers_due.push_back(a);
  endfunction

  function void check_answer(logic hit, logic [47:0] mac, logic full);
    cache_answer_t e;
    if (answers_due.size() == 0) begin
      $display("%0t: answer with nothing pending: hit %0b mac %h full %0b",
               $time, hit, mac, full);
      errors++;
      return;
    end
    e = answers_due.pop_front();
    if (hit !== e.hit) begin
      $display("%0t: hit expected %0b, got %0b", $time, e.hit, hit);
      errors++;
    end
    if (mac !== e.mac) begin
      $display("%0t: found_mac expected %h, got %h", $time, e.mac, mac);
      errors++;
    end
    if (full !== e.full) begin
      $display("%0t: table_full expected %0b, got %0b", $time, e.full, full);
      errors++;
    end
  endfunction
endclass

module arp_cache_with_aging_test import arpc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int POOL = 24;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [LIFE_W-1:0] cfg_wr_data;

  arpc_in_if  in_ch();
  arpc_out_if out_ch();

  mac_table book = new;
  int       hold_req = 0;
  bit       calm = 1'b0;
  logic [IP_W-1:0] ip_pool[POOL];

  arp_cache_with_aging i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch.sink),
    .out_if      (out_ch.source),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [MAC_W-1:0] any_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic push_item(logic [ACT_W-1:0] act, logic [IP_W-1:0] ip,
                           logic [MAC_W-1:0] mac);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.ip_address  <= ip;
    in_ch.mac_address <= mac;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    book.note_request(act, ip, mac);
  endtask

  // wait for every answer, then let a trailing tick finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (book.answers_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_lifetime(logic [LIFE_W-1:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    book.lifetime = v;
  endtask

  task automatic random_phase(int n);
    int r;
    for (int k = 0; k < POOL; k++) ip_pool[k] = $urandom;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 34)
        push_item(ACT_LOOKUP, ip_pool[$urandom_range(0, POOL-1)], any_mac());
      else if (r < 38)
        push_item(ACT_LOOKUP, $urandom, any_mac());
      else if (r < 75)
        push_item(ACT_INSERT, ip_pool[$urandom_range(0, POOL-1)], any_mac());
      else if (r < 94)
        push_item(ACT_TICK, $urandom, any_mac());
      else
        push_item(ACT_UNUSED, $urandom, any_mac());
    end
  endtask

  initial begin : answer_sink
    int stall_left;
    int g;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        book.check_answer(out_ch.hit, out_ch.found_mac, out_ch.table_full);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        g = calm ? 0 : pick_gap();
        if (g == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          stall_left = g - 1;
        end
      end
    end
  end

  initial begin
    rst_n             <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.action      <= ACT_LOOKUP;
    in_ch.ip_address  <= '0;
    in_ch.mac_address <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, extremes, duplicate insert, full table
    push_item(ACT_LOOKUP, 32'h0000_0000, 48'h0);
    push_item(ACT_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    push_item(ACT_INSERT, 32'h0000_0000, 48'h0);
    push_item(ACT_INSERT, 32'hFFFF_FFFF, 48'h0123_4567_89AB);
    push_item(ACT_LOOKUP, 32'hFFFF_FFFF, 48'h0);
    push_item(ACT_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    push_item(ACT_UNUSED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    for (int k = 0; k < 14; k++)
      push_item(ACT_INSERT, 32'h0A00_0001 + 32'(k), any_mac());
    push_item(ACT_INSERT, 32'h0B00_0000, 48'hAAAA_5555_AAAA);
    push_item(ACT_LOOKUP, 32'h0B00_0000, 48'h0);
    push_item(ACT_TICK, 32'h0, 48'h0);
    settle();

    random_phase(60);
    set_lifetime(16'd0);
    random_phase(50);
    set_lifetime(16'd1);
    calm = 1'b1;
    random_phase(60);

    // long receiver hold while requests keep coming
    hold_req = 300;
    for (int k = 0; k < 10; k++)
      push_item(ACT_LOOKUP, ip_pool[$urandom_range(0, POOL-1)], any_mac());
    calm = 1'b0;

    set_lifetime(16'hFFFF);
    random_phase(70);
    set_lifetime(16'd3);
    calm = 1'b1;
    random_phase(60);
    calm = 1'b0;
    set_lifetime(16'($urandom_range(4, 40)));
    random_phase(70);
    settle();
    repeat (40) @(posedge clk);

    $display("covered %0d lookups and %0d inserts (%0d hits, %0d dropped on a full table)",
             book.n_lookup, book.n_insert, book.n_hit, book.n_full);
    $display("over %0d ticks and lifetimes 15, 0, 1, 65535, 3 and a random one",
             book.n_tick);
    if (book.errors == 0 && book.answers_due.size() == 0) begin
      $display("arp_cache_with_aging_test: done, clean");
    end else begin
      $display("arp_cache_with_aging_test: done, errors");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("timeout with %0d answers outstanding", book.answers_due.size());
    $display("arp_cache_with_aging_test: done, errors");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/core/arpc_pkg.sv
rtl/core/arpc_in_if.sv
rtl/core/arpc_out_if.sv
rtl/core/arpc_cell.sv
rtl/core/arp_cache_with_aging.sv
tb/sv/arp_cache_with_aging_test.sv
